>>> hw/rtl/tlvks_pkg.sv
// Shared constants for the TLV record key search core.
`timescale 1ns / 1ps

package tlvks_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEARCH_KEY = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INT_TYPE   = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REAL_TYPE  = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXT_TYPE  = 4'd3;

   // Configuration reset values
   localparam logic [31:0] SEARCH_KEY_RESET = 32'd0;
   localparam logic [7:0]  INT_TYPE_RESET   = 8'd0;
   localparam logic [7:0]  REAL_TYPE_RESET  = 8'd1;
   localparam logic [7:0]  TEXT_TYPE_RESET  = 8'd2;

   // Result status codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // Reported record types
   localparam logic [1:0] KIND_INT  = 2'd0;
   localparam logic [1:0] KIND_REAL = 2'd1;
   localparam logic [1:0] KIND_TEXT = 2'd2;

endpackage

>>> hw/rtl/tlv_record_key_search_core.sv
// TLV record key search core: parses a record byte stream and reports the first key match.
//
// One payload byte is taken per cycle, back to back, with no gaps between records or payloads.
// Each accepted item updates the parser state in the same cycle; an answer (found, clean end
// without a match, or malformed) is loaded into the output register and shows on rsp_* in the
// cycle after the transfer that caused it. At most one answer is given per payload; bytes after
// it are dropped until end_of_payload. req_ready stays high unless a held answer is not being
// taken, so the only thing that slows input is back-pressure on the result channel. Writes on
// the csr_* port are always accepted and should be made while no payload is in progress.
`timescale 1ns / 1ps

module tlv_record_key_search_core #(
   parameter int POSITION_BITS = tlvks_pkg::POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_payload,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_found_type,
   output logic [63:0] rsp_value_bits,
   output logic [30:0] rsp_text_length,
   output logic [31:0] rsp_text_offset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tlvks_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   // Parse phases
   localparam logic [2:0] PH_KEY   = 3'd0;
   localparam logic [2:0] PH_TYPE  = 3'd1;
   localparam logic [2:0] PH_VALUE = 3'd2;
   localparam logic [2:0] PH_TLEN  = 3'd3;
   localparam logic [2:0] PH_TEXT  = 3'd4;

   localparam int LW = (POSITION_BITS > 31) ? POSITION_BITS : 31;

   // configuration
   logic [31:0] search_key_ff;
   logic [7:0]  int_type_ff, real_type_ff, text_type_ff;

   // parser state
   logic [2:0]               phase_ff, phase_in;
   logic [2:0]               idx_ff, idx_in;
   logic [31:0]              key_ff, key_in;
   logic [1:0]               kind_ff, kind_in;
   logic [63:0]              val_ff, val_in;
   logic [30:0]              rem_ff, rem_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     answered_ff, answered_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [1:0]  ftype_ff, ftype_in;
   logic [63:0] vbits_ff, vbits_in;
   logic [30:0] tlen_ff, tlen_in;
   logic [31:0] toff_ff, toff_in;

   logic                     req_fire, rsp_fire, byte_go, hit, rec_done;
   logic [POSITION_BITS-1:0] pos_after, off_p;
   logic [LW-1:0]            off_w;
   logic [30:0]              len_sel;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;
   assign byte_go   = req_fire && req_byte_valid && !answered_ff;
   assign pos_after = pos_ff + POSITION_BITS'(1);

   // text offset = position after the last text byte minus the text length, modulo position size
   assign len_sel = (phase_ff == PH_TLEN) ? 31'd0 : val_ff[30:0];
   assign off_w   = LW'(pos_after) - LW'(len_sel);
   assign off_p   = off_w[POSITION_BITS-1:0];

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      key_in      = key_ff;
      kind_in     = kind_ff;
      val_in      = val_ff;
      rem_in      = rem_ff;
      pos_in      = pos_ff;
      answered_in = answered_ff;
      hit         = 1'b0;
      rec_done    = 1'b0;
      status_in   = tlvks_pkg::ST_FOUND;
      ftype_in    = tlvks_pkg::KIND_INT;
      vbits_in    = 64'd0;
      tlen_in     = 31'd0;
      toff_in     = 32'd0;

      if (byte_go) begin
         pos_in = pos_after;
         unique case (phase_ff)
            PH_KEY: begin
               key_in[{idx_ff[1:0], 3'b000} +: 8] = req_data_byte;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd3) begin
                  idx_in   = 3'd0;
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               val_in = 64'd0;
               idx_in = 3'd0;
               if (req_data_byte == int_type_ff) begin
                  kind_in  = tlvks_pkg::KIND_INT;
                  phase_in = PH_VALUE;
               end else if (req_data_byte == real_type_ff) begin
                  kind_in  = tlvks_pkg::KIND_REAL;
                  phase_in = PH_VALUE;
               end else if (req_data_byte == text_type_ff) begin
                  kind_in  = tlvks_pkg::KIND_TEXT;
                  phase_in = PH_TLEN;
               end else begin
                  answered_in = 1'b1;
                  hit         = 1'b1;
                  status_in   = tlvks_pkg::ST_MALFORMED;
               end
            end
            PH_VALUE: begin
               val_in[{idx_ff, 3'b000} +: 8] = req_data_byte;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  rec_done = 1'b1;
               end
            end
            PH_TLEN: begin
               val_in[{idx_ff[1:0], 3'b000} +: 8] = req_data_byte;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd3) begin
                  idx_in = 3'd0;
                  if (req_data_byte[7]) begin
                     answered_in = 1'b1;
                     hit         = 1'b1;
                     status_in   = tlvks_pkg::ST_MALFORMED;
                  end else begin
                     rem_in = val_in[30:0];
                     if (val_in[30:0] == 31'd0) begin
                        rec_done = 1'b1;
                     end else begin
                        phase_in = PH_TEXT;
                     end
                  end
               end
            end
            PH_TEXT: begin
               rem_in = rem_ff - 31'd1;
               if (rem_ff == 31'd1) begin
                  rec_done = 1'b1;
               end
            end
            default: begin
               phase_in = PH_KEY;
            end
         endcase

         if (rec_done) begin
            if (key_ff == search_key_ff) begin
               answered_in = 1'b1;
               hit         = 1'b1;
               status_in   = tlvks_pkg::ST_FOUND;
               ftype_in    = kind_ff;
               if (kind_ff == tlvks_pkg::KIND_TEXT) begin
                  tlen_in = val_in[30:0];
                  toff_in = 32'(off_p);
               end else begin
                  vbits_in = val_in;
               end
            end else begin
               phase_in = PH_KEY;
               idx_in   = 3'd0;
               key_in   = 32'd0;
               val_in   = 64'd0;
            end
         end
      end

      if (req_fire && req_end_of_payload) begin
         if (!answered_in) begin
            hit       = 1'b1;
            status_in = (phase_in == PH_KEY && idx_in == 3'd0) ? tlvks_pkg::ST_NOT_FOUND
                                                               : tlvks_pkg::ST_MALFORMED;
         end
         phase_in    = PH_KEY;
         idx_in      = 3'd0;
         key_in      = 32'd0;
         kind_in     = tlvks_pkg::KIND_INT;
         val_in      = 64'd0;
         rem_in      = 31'd0;
         pos_in      = '0;
         answered_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_key_ff <= tlvks_pkg::SEARCH_KEY_RESET;
         int_type_ff   <= tlvks_pkg::INT_TYPE_RESET;
         real_type_ff  <= tlvks_pkg::REAL_TYPE_RESET;
         text_type_ff  <= tlvks_pkg::TEXT_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tlvks_pkg::CSR_SEARCH_KEY: search_key_ff <= csr_wdata;
            tlvks_pkg::CSR_INT_TYPE:   int_type_ff   <= csr_wdata[7:0];
            tlvks_pkg::CSR_REAL_TYPE:  real_type_ff  <= csr_wdata[7:0];
            tlvks_pkg::CSR_TEXT_TYPE:  text_type_ff  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_KEY;
         idx_ff       <= 3'd0;
         key_ff       <= 32'd0;
         kind_ff      <= tlvks_pkg::KIND_INT;
         val_ff       <= 64'd0;
         rem_ff       <= 31'd0;
         pos_ff       <= '0;
         answered_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         key_ff       <= key_in;
         kind_ff      <= kind_in;
         val_ff       <= val_in;
         rem_ff       <= rem_in;
         pos_ff       <= pos_in;
         answered_ff  <= answered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only on a new answer
   always_ff @(posedge clock) begin
      if (hit) begin
         status_ff <= status_in;
         ftype_ff  <= ftype_in;
         vbits_ff  <= vbits_in;
         tlen_ff   <= tlen_in;
         toff_ff   <= toff_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_type  = ftype_ff;
   assign rsp_value_bits  = vbits_ff;
   assign rsp_text_length = tlen_ff;
   assign rsp_text_offset = toff_ff;

`ifndef SYNTHESIS
   a_text_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TEXT && !answered_ff) |-> rem_ff != 31'd0)
      else $error("text phase entered with no bytes remaining");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_end_of_payload) |=>
         (phase_ff == PH_KEY && idx_ff == 3'd0 && !answered_ff && pos_ff == '0))
      else $error("parser not cleared after end of payload");

   a_miss_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != tlvks_pkg::ST_FOUND) |->
         (rsp_found_type == tlvks_pkg::KIND_INT && rsp_value_bits == 64'd0 &&
          rsp_text_length == 31'd0 && rsp_text_offset == 32'd0))
      else $error("non-found answer carries record fields");

   a_text_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == tlvks_pkg::ST_FOUND &&
       rsp_found_type == tlvks_pkg::KIND_TEXT) |-> rsp_value_bits == 64'd0)
      else $error("text answer carries value bits");

   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      (answered_ff && !(req_fire && req_end_of_payload)) |=> answered_ff)
      else $error("answered flag dropped before end of payload");
`endif

endmodule

>>> tb/sv/tb_tlv_record_key_search_core.sv
// Self-checking testbench for the TLV record key search core.
`timescale 1ns / 1ps

module tb_tlv_record_key_search_core;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  kind;
      logic [63:0] value;
      logic [30:0] text_len;
      logic [31:0] text_off;
   } answer_type;

   typedef logic [7:0] octet_q_type[$];

   // Tracks the record parser and holds the answers still owed by the core.
   class tlv_search_scoreboard;
      typedef enum logic [2:0] {P_KEY, P_TYPE, P_VALUE, P_TLEN, P_TEXT} parse_type;

      logic [31:0] key_reg;
      logic [7:0]  int_code;
      logic [7:0]  real_code;
      logic [7:0]  text_code;

      parse_type   phase;
      int          idx;
      logic [31:0] key_acc;
      logic [1:0]  kind;
      logic [63:0] value_acc;
      logic [30:0] text_left;
      logic [31:0] pos;
      bit          answered;

      answer_type  answers[$];
      int          errors;

      function new();
         key_reg   = tlvks_pkg::SEARCH_KEY_RESET;
         int_code  = tlvks_pkg::INT_TYPE_RESET;
         real_code = tlvks_pkg::REAL_TYPE_RESET;
         text_code = tlvks_pkg::TEXT_TYPE_RESET;
         errors    = 0;
         restart_payload();
      endfunction

      function void restart_payload();
         phase     = P_KEY;
         idx       = 0;
         key_acc   = '0;
         kind      = tlvks_pkg::KIND_INT;
         value_acc = '0;
         text_left = '0;
         pos       = '0;
         answered  = 1'b0;
      endfunction

      function int pending();
         return answers.size();
      endfunction

      function void write_reg(logic [tlvks_pkg::CSR_INDEX_BITS-1:0] index, logic [31:0] data);
         case (index)
            tlvks_pkg::CSR_SEARCH_KEY: key_reg = data;
            tlvks_pkg::CSR_INT_TYPE:   int_code = data[7:0];
            tlvks_pkg::CSR_REAL_TYPE:  real_code = data[7:0];
            tlvks_pkg::CSR_TEXT_TYPE:  text_code = data[7:0];
            default: ;
         endcase
      endfunction

      function void add_answer(logic [1:0] st, logic [1:0] k, logic [63:0] v,
                               logic [30:0] len, logic [31:0] off);
         answer_type a;
         a.status   = st;
         a.kind     = k;
         a.value    = v;
         a.text_len = len;
         a.text_off = off;
         answers.insert(answers.size(), a);
      endfunction

      function void malformed();
         answered = 1'b1;
         add_answer(tlvks_pkg::ST_MALFORMED, '0, '0, '0, '0);
      endfunction

      // pos_after is the position just past the record's last byte
      function void close_record(logic [31:0] pos_after);
         if (key_acc == key_reg) begin
            answered = 1'b1;
            if (kind == tlvks_pkg::KIND_TEXT)
               add_answer(tlvks_pkg::ST_FOUND, tlvks_pkg::KIND_TEXT, '0, value_acc[30:0],
                          pos_after - {1'b0, value_acc[30:0]});
            else
               add_answer(tlvks_pkg::ST_FOUND, kind, value_acc, '0, '0);
         end else begin
            phase     = P_KEY;
            idx       = 0;
            key_acc   = '0;
            value_acc = '0;
         end
      endfunction

      function void take_byte(logic [7:0] b);
         logic [31:0] pos_next;
         pos_next = pos + 32'd1;
         case (phase)
            P_KEY: begin
               key_acc |= 32'(b) << (8 * idx);
               idx++;
               if (idx == 4) begin
                  idx   = 0;
                  phase = P_TYPE;
               end
            end
            P_TYPE: begin
               value_acc = '0;
               idx       = 0;
               // integer code wins over double, double over text
               if (b == int_code) begin
                  kind  = tlvks_pkg::KIND_INT;
                  phase = P_VALUE;
               end else if (b == real_code) begin
                  kind  = tlvks_pkg::KIND_REAL;
                  phase = P_VALUE;
               end else if (b == text_code) begin
                  kind  = tlvks_pkg::KIND_TEXT;
                  phase = P_TLEN;
               end else begin
                  malformed();
               end
            end
            P_VALUE: begin
               value_acc |= 64'(b) << (8 * idx);
               idx++;
               if (idx == 8)
                  close_record(pos_next);
            end
            P_TLEN: begin
               value_acc |= 64'(b) << (8 * idx);
               idx++;
               if (idx == 4) begin
                  idx = 0;
                  if (value_acc[31]) begin
                     malformed();
                  end else begin
                     text_left = value_acc[30:0];
                     if (text_left == 0)
                        close_record(pos_next);
                     else
                        phase = P_TEXT;
                  end
               end
            end
            default: begin
               if (text_left != 0)
                  text_left--;
               if (text_left == 0)
                  close_record(pos_next);
            end
         endcase
         pos = pos_next;
      endfunction

      function void note_item(logic [7:0] b, logic bv, logic eop);
         if (bv && !answered)
            take_byte(b);
         if (eop) begin
            if (!answered)
               add_answer((phase == P_KEY && idx == 0) ? tlvks_pkg::ST_NOT_FOUND
                                                       : tlvks_pkg::ST_MALFORMED,
                          '0, '0, '0, '0);
            restart_payload();
         end
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected answer, expected none, actual status %0d",
                     $time, got.status);
            return;
         end
         want = answers.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("found_type", 64'(want.kind), 64'(got.kind));
         compare_field("value_bits", want.value, got.value);
         compare_field("text_length", 64'(want.text_len), 64'(got.text_len));
         compare_field("text_offset", 64'(want.text_off), 64'(got.text_off));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_payload = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_found_type;
   logic [63:0] rsp_value_bits;
   logic [30:0] rsp_text_length;
   logic [31:0] rsp_text_offset;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [tlvks_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   tlv_search_scoreboard sb;

   bit          idling = 1'b1;
   bit          hold_results = 1'b0;
   int          sent = 0;

   // key and type codes as programmed, used to shape the generated records
   logic [31:0] cur_key = tlvks_pkg::SEARCH_KEY_RESET;
   logic [7:0]  cur_int = tlvks_pkg::INT_TYPE_RESET;
   logic [7:0]  cur_real = tlvks_pkg::REAL_TYPE_RESET;
   logic [7:0]  cur_text = tlvks_pkg::TEXT_TYPE_RESET;

   tlv_record_key_search_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_payload (req_end_of_payload),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_type     (rsp_found_type),
      .rsp_value_bits     (rsp_value_bits),
      .rsp_text_length    (rsp_text_length),
      .rsp_text_offset    (rsp_text_offset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // transfers are sampled before this edge's updates land
   always @(posedge clock) begin : monitor
      answer_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_item(req_data_byte, req_byte_valid, req_end_of_payload);
         if (rsp_valid && rsp_ready) begin
            seen.status   = rsp_status;
            seen.kind     = rsp_found_type;
            seen.value    = rsp_value_bits;
            seen.text_len = rsp_text_length;
            seen.text_off = rsp_text_offset;
            sb.check_answer(seen);
         end
      end
   end

   // result side: random stalls while idling is set, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_results = 1'b0;
         end else if (idling && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic push_item(input logic [7:0] b, input logic bv, input logic eop);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_byte_valid     <= bv;
      req_end_of_payload <= eop;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_bytes(input octet_q_type bytes, input bit end_apart);
      int i;
      bit split;
      split = end_apart || bytes.size() == 0;
      for (i = 0; i < bytes.size(); i++) begin
         if ($urandom_range(0, 15) == 0)
            push_item(8'($urandom), 1'b0, 1'b0);
         push_item(bytes[i], 1'b1, !split && i == bytes.size() - 1);
         sent++;
      end
      if (split) begin
         push_item(8'($urandom), 1'b0, 1'b1);
         sent++;
      end
   endtask

   // wait out every owed answer, then the core's pipeline
   task automatic settle();
      req_valid <= 1'b0;
      // let the monitor note the last accepted transfer first
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tlvks_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input logic [31:0] key, input logic [7:0] ic,
                               input logic [7:0] rc, input logic [7:0] tc);
      csr_write(tlvks_pkg::CSR_SEARCH_KEY, key);
      csr_write(tlvks_pkg::CSR_INT_TYPE, {24'd0, ic});
      csr_write(tlvks_pkg::CSR_REAL_TYPE, {24'd0, rc});
      csr_write(tlvks_pkg::CSR_TEXT_TYPE, {24'd0, tc});
      csr_valid <= 1'b0;
      cur_key  = key;
      cur_int  = ic;
      cur_real = rc;
      cur_text = tc;
   endtask

   function automatic octet_q_type make_payload();
      octet_q_type q;
      int          n_rec;
      int          r;
      int          k;
      int          pick;
      logic [31:0] key;
      logic [31:0] tlen;
      logic [7:0]  code;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 20)) q.insert(q.size(), 8'($urandom));
         return q;
      end
      n_rec = $urandom_range(0, 3);
      for (r = 0; r < n_rec; r++) begin
         case ($urandom_range(0, 2))
            0: key = $urandom;
            1: key = cur_key ^ (32'd1 << $urandom_range(0, 31));
            default: key = cur_key;
         endcase
         for (k = 0; k < 4; k++)
            q.insert(q.size(), key[8 * k +: 8]);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            do code = 8'($urandom);
            while (code == cur_int || code == cur_real || code == cur_text);
            q.insert(q.size(), code);
         end else if (pick < 13) begin
            q.insert(q.size(), pick < 8 ? cur_int : cur_real);
            repeat (8) q.insert(q.size(), 8'($urandom));
         end else begin
            q.insert(q.size(), cur_text);
            case ($urandom_range(0, 19))
               0: tlen = 32'h8000_0000 | $urandom;
               1: tlen = {1'b0, 31'($urandom)};
               default: tlen = $urandom_range(0, 12);
            endcase
            for (k = 0; k < 4; k++)
               q.insert(q.size(), tlen[8 * k +: 8]);
            if (tlen <= 12)
               repeat (tlen) q.insert(q.size(), 8'($urandom));
            else
               repeat ($urandom_range(0, 5)) q.insert(q.size(), 8'($urandom));
         end
      end
      case ($urandom_range(0, 9))
         0: if (q.size() > 0)
               repeat ($urandom_range(1, q.size())) void'(q.pop_back());
         1: repeat ($urandom_range(1, 6)) q.insert(q.size(), 8'($urandom));
         default: ;
      endcase
      return q;
   endfunction

   initial begin : stimulus
      octet_q_type q;
      int phase_now;
      int phase_seen;
      int waited;
      bit hold_done;
      sb = new();
      hold_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no byte and no end: ignored
      push_item(8'hFF, 1'b0, 1'b0);
      // empty payload ends cleanly
      push_item(8'h00, 1'b0, 1'b1);
      // matching key but unknown type byte, end in the same transfer
      q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
      send_bytes(q, 1'b0);
      // negative text length, then an end after the answer
      q = '{8'h01, 8'h02, 8'h03, 8'h04, tlvks_pkg::TEXT_TYPE_RESET,
            8'h00, 8'h00, 8'h00, 8'h80};
      send_bytes(q, 1'b1);
      // zero-length text that matches
      q = '{8'h00, 8'h00, 8'h00, 8'h00, tlvks_pkg::TEXT_TYPE_RESET,
            8'h00, 8'h00, 8'h00, 8'h00};
      send_bytes(q, 1'b0);

      sent = 0;
      phase_seen = 0;
      while (sent < 850) begin
         phase_now = sent / 142;
         if (phase_now != phase_seen) begin
            phase_seen = phase_now;
            settle();
            case (phase_now)
               1: program_regs($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
               2: program_regs(32'h8000_0000, 8'hFF, 8'h00, 8'h80);
               3: program_regs(32'h7FFF_FFFF, 8'h05, 8'h05, 8'h07);
               4: program_regs(32'hFFFF_FFFF, 8'h03, 8'h09, 8'h09);
               default: begin
                  program_regs($urandom, 8'h2A, 8'h2B, 8'h2A);
                  idling = 1'b0;
               end
            endcase
         end
         if (!hold_done && sent >= 300) begin
            hold_results = 1'b1;
            hold_done = 1'b1;
         end
         send_bytes(make_payload(), $urandom_range(0, 2) == 0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (sb.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0t: %0d expected answers never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
